FILE: hw/rtl/b2bcd_pkg.sv
// Shared constants, types and arithmetic helpers for the binary to packed BCD converter.
package b2bcd_pkg;

  localparam int unsigned ValueW          = 32;
  localparam int unsigned CountW          = 3;
  localparam int unsigned ByteW           = 8;
  localparam int unsigned IdxW            = 3;
  localparam int unsigned MaxBytesDefault = 5;
  localparam int unsigned InTdataW        = 40;
  localparam int unsigned OutTdataW       = 16;

  // floor(v / 100) == (v * Div100Magic) >> Div100Shift for every 32-bit v.
  localparam logic [ValueW-1:0] Div100Magic = 32'd1374389535;
  localparam int unsigned       Div100Shift = 37;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [CountW-1:0] count;
    logic              bad;
  } b2bcd_item_t;

  function automatic logic [ValueW-1:0] div100(logic [ValueW-1:0] v);
    logic [2*ValueW-1:0] prod;
    prod = {{ValueW{1'b0}}, v} * {{ValueW{1'b0}}, Div100Magic};
    return ValueW'(prod >> Div100Shift);
  endfunction

  // Splits a value below 100 into tens and units nibbles.
  function automatic logic [ByteW-1:0] pair_to_bcd(logic [6:0] r);
    logic [14:0] t;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [6:0]  units;
    t        = 15'(r) * 15'd205;
    tens     = t[14:11];
    tens_x10 = 7'(tens) * 7'd10;
    units    = r - tens_x10;
    return {tens, units[3:0]};
  endfunction

endpackage

FILE: hw/rtl/binary_to_packed_bcd.sv
// Top level of the binary to packed BCD converter: input stage, job queue and engine.
//
// Channel   Dir  tdata (low bit up)                         tlast    tuser
// s_axis    in   value[31:0], byte_count[34:32], pad to 40  -        -
// m_axis    out  bcd_byte[7:0], byte_index[10:8], pad to 16 is_last  bad_count
//
// Each input word yields byte_count output words (one for a rejected count), least
// significant digit pair first; the engine delivers one word per cycle while the output
// is not stalled. The engine divides by 100 with one reciprocal multiply per cycle
// unless the output stalls; that loop sets the rate.
// Reset (rst_ni, asynchronous, active low) empties the queue and all pipeline stages.
// A stalled output holds its word; the queue lets the input side keep accepting until full.
module binary_to_packed_bcd #(
  parameter int unsigned MAX_BYTES = b2bcd_pkg::MaxBytesDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // value[31:0], byte_count[34:32], zeros above.
  input  logic [b2bcd_pkg::InTdataW-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // bcd_byte[7:0], byte_index[10:8], zeros above.
  output logic [b2bcd_pkg::OutTdataW-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast,
  // bad_count.
  output logic                                m_axis_tuser
);

  logic                           push;
  logic                           full;
  logic                           pop;
  logic                           job_valid;
  b2bcd_pkg::b2bcd_item_t         front_item;
  b2bcd_pkg::b2bcd_item_t         job;
  logic [b2bcd_pkg::ByteW-1:0]    bcd_byte;
  logic [b2bcd_pkg::IdxW-1:0]     byte_index;

  // The input stage splits tdata into fields and flags counts out of range.
  b2bcd_front #(
    .MAX_BYTES (MAX_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .value_i    (s_axis_tdata[31:0]),
    .count_i    (s_axis_tdata[34:32]),
    .full_i     (full),
    .push_o     (push),
    .item_o     (front_item)
  );

  // The queue decouples acceptance from the multi-cycle conversion.
  b2bcd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .item_o  (job)
  );

  // The engine emits one packed BCD byte per cycle into its output register when not stalled.
  b2bcd_back #(
    .MAX_BYTES (MAX_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (job_valid),
    .job_i        (job),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .bcd_byte_o   (bcd_byte),
    .byte_index_o (byte_index),
    .is_last_o    (m_axis_tlast),
    .bad_count_o  (m_axis_tuser)
  );

  assign m_axis_tdata = {5'd0, byte_index, bcd_byte};

endmodule

FILE: hw/rtl/b2bcd_front.sv
// Input stage: takes words, checks the byte count and hands jobs to the queue.
module b2bcd_front #(
  parameter int unsigned MAX_BYTES = b2bcd_pkg::MaxBytesDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [b2bcd_pkg::ValueW-1:0]   value_i,
  input  logic [b2bcd_pkg::CountW-1:0]   count_i,
  input  logic                           full_i,
  output logic                           push_o,
  output b2bcd_pkg::b2bcd_item_t         item_o
);

  logic                   valid_q;
  logic                   valid_d;
  b2bcd_pkg::b2bcd_item_t item_q;
  logic                   bad;

  assign bad        = (count_i == '0) || (int'(count_i) > int'(MAX_BYTES));
  assign push_o     = valid_q && !full_i;
  assign in_ready_o = !valid_q || push_o;
  assign item_o     = item_q;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q.value <= value_i;
      item_q.count <= count_i;
      item_q.bad   <= bad;
    end
  end

endmodule

FILE: hw/rtl/b2bcd_fifo.sv
// Two-entry job queue between the input stage and the conversion engine.
module b2bcd_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  b2bcd_pkg::b2bcd_item_t item_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output logic                   valid_o,
  output b2bcd_pkg::b2bcd_item_t item_o
);

  b2bcd_pkg::b2bcd_item_t mem_q [2];
  logic                   wr_ptr_q;
  logic                   rd_ptr_q;
  logic [1:0]             cnt_q;
  logic [1:0]             cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: hw/rtl/b2bcd_back.sv
// Conversion engine: emits one digit pair per unstalled cycle to the output register.
module b2bcd_back #(
  parameter int unsigned MAX_BYTES = b2bcd_pkg::MaxBytesDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           job_valid_i,
  input  b2bcd_pkg::b2bcd_item_t         job_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [b2bcd_pkg::ByteW-1:0]    bcd_byte_o,
  output logic [b2bcd_pkg::IdxW-1:0]     byte_index_o,
  output logic                           is_last_o,
  output logic                           bad_count_o
);

  localparam int unsigned LeftW = $clog2(MAX_BYTES + 1);

  // Job register: value still to divide and bytes left.
  logic                          busy_q;
  logic                          busy_d;
  logic [b2bcd_pkg::ValueW-1:0]  v_q;
  logic [LeftW-1:0]              left_q;
  logic [b2bcd_pkg::IdxW-1:0]    idx_q;
  logic                          bad_q;

  // Divide stage: low bits of dividend and quotient.
  logic                          s2_valid_q;
  logic                          s2_valid_d;
  logic [6:0]                    s2_v_q;
  logic [6:0]                    s2_quo_q;
  logic [b2bcd_pkg::IdxW-1:0]    s2_idx_q;
  logic                          s2_last_q;
  logic                          s2_bad_q;

  // Output register.
  logic                          out_valid_q;
  logic                          out_valid_d;
  logic [b2bcd_pkg::ByteW-1:0]   out_byte_q;
  logic [b2bcd_pkg::IdxW-1:0]    out_idx_q;
  logic                          out_last_q;
  logic                          out_bad_q;

  logic                          out_adv;
  logic                          s2_adv;
  logic                          emit;
  logic                          job_last;
  logic [b2bcd_pkg::ValueW-1:0]  quo;
  logic [6:0]                    quo_x100;
  logic [6:0]                    rem;

  assign out_adv  = !out_valid_q || out_ready_i;
  assign s2_adv   = !s2_valid_q || out_adv;
  assign emit     = busy_q && s2_adv;
  assign job_last = (left_q == LeftW'(1));
  assign pop_o    = job_valid_i && (!busy_q || (emit && job_last));
  assign quo      = b2bcd_pkg::div100(v_q);

  // Remainder fits in seven bits, so only the low bits take part.
  assign quo_x100 = s2_quo_q * 7'd100;
  assign rem      = s2_v_q - quo_x100;

  always_comb begin
    busy_d = busy_q;
    if (pop_o) begin
      busy_d = 1'b1;
    end else if (emit && job_last) begin
      busy_d = 1'b0;
    end
  end

  always_comb begin
    s2_valid_d = s2_valid_q;
    if (s2_adv) begin
      s2_valid_d = emit;
    end
    out_valid_d = out_valid_q;
    if (out_adv) begin
      out_valid_d = s2_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      // A rejected count turns into a single zero byte.
      v_q    <= job_i.bad ? '0 : job_i.value;
      left_q <= job_i.bad ? LeftW'(1) : LeftW'(job_i.count);
      idx_q  <= '0;
      bad_q  <= job_i.bad;
    end else if (emit) begin
      v_q    <= quo;
      left_q <= left_q - LeftW'(1);
      idx_q  <= idx_q + b2bcd_pkg::IdxW'(1);
    end
    if (emit) begin
      s2_v_q    <= v_q[6:0];
      s2_quo_q  <= quo[6:0];
      s2_idx_q  <= idx_q;
      s2_last_q <= job_last;
      s2_bad_q  <= bad_q;
    end
    if (out_adv && s2_valid_q) begin
      out_byte_q <= b2bcd_pkg::pair_to_bcd(rem);
      out_idx_q  <= s2_idx_q;
      out_last_q <= s2_last_q;
      out_bad_q  <= s2_bad_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign bcd_byte_o   = out_byte_q;
  assign byte_index_o = out_idx_q;
  assign is_last_o    = out_last_q;
  assign bad_count_o  = out_bad_q;

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the binary to packed BCD converter.

typedef struct packed {
  logic [7:0] bcd_byte;
  logic [2:0] byte_index;
  logic       is_last;
  logic       bad_count;
} bcd_word_t;

// Keeps the words the converter owes, in order, and checks each delivered word.
class bcd_scoreboard;
  bcd_word_t   owed_words[$];
  int unsigned mismatches = 0;

  task report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Works out the words one accepted input owes: each pass peels off the lowest
  // two decimal digits, so byte k holds digits 2k+1 and 2k of the value.
  function void note_input(logic [31:0] value, logic [2:0] byte_count);
    logic [31:0] rest;
    logic [6:0]  pair;
    bcd_word_t   w;
    if (byte_count == 3'd0 || byte_count > b2bcd_pkg::MaxBytesDefault) begin
      w = '{bcd_byte: 8'd0, byte_index: 3'd0, is_last: 1'b1, bad_count: 1'b1};
      owed_words.push_back(w);
    end else begin
      rest = value;
      for (int k = 0; k < byte_count; k++) begin
        pair         = 7'(rest % 32'd100);
        rest         = rest / 32'd100;
        w.bcd_byte   = {4'(pair / 7'd10), 4'(pair % 7'd10)};
        w.byte_index = 3'(k);
        w.is_last    = (k == byte_count - 1);
        w.bad_count  = 1'b0;
        owed_words.push_back(w);
      end
    end
  endfunction

  task check_word(logic [b2bcd_pkg::OutTdataW-1:0] tdata, logic tlast, logic tuser);
    bcd_word_t want;
    if (owed_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word tdata=%h last=%b user=%b",
                                tdata, tlast, tuser));
    end else begin
      want = owed_words.pop_front();
      if (tdata[7:0] !== want.bcd_byte)
        report_mismatch($sformatf("bcd_byte %h, want %h", tdata[7:0], want.bcd_byte));
      if (tdata[10:8] !== want.byte_index)
        report_mismatch($sformatf("byte_index %0d, want %0d", tdata[10:8], want.byte_index));
      if (tlast !== want.is_last)
        report_mismatch($sformatf("is_last %b, want %b", tlast, want.is_last));
      if (tuser !== want.bad_count)
        report_mismatch($sformatf("bad_count %b, want %b", tuser, want.bad_count));
    end
  endtask

  function int unsigned pending();
    return owed_words.size();
  endfunction
endclass

module tb_top;

  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  // value[31:0], byte_count[34:32], zeros above.
  logic [b2bcd_pkg::InTdataW-1:0]    s_axis_tdata  = '0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  // bcd_byte[7:0], byte_index[10:8], zeros above.
  logic [b2bcd_pkg::OutTdataW-1:0]   m_axis_tdata;
  logic                              m_axis_tlast;
  // bad_count.
  logic                              m_axis_tuser;

  bcd_scoreboard digits_sb = new();

  // When cleared, neither side idles: used for the closing stretch of the run.
  bit idling_on = 1'b1;

  binary_to_packed_bcd dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Output side: ready runs in bursts of random length, either high or low. Each
  // falling edge gets exactly one assignment to ready.
  initial begin
    int unsigned burst;
    forever begin
      burst = $urandom_range(1, 12);
      if (idling_on && $urandom_range(0, 2) == 0) begin
        repeat (burst) begin
          @(negedge clk_i);
          m_axis_tready <= 1'b0;
        end
      end else begin
        repeat (burst) begin
          @(negedge clk_i);
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // Sampled at the rising edge, before the design's own updates land.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      digits_sb.check_word(m_axis_tdata, m_axis_tlast, m_axis_tuser);
  end

  // Offers one word, optionally after a gap of idle cycles, and returns once it
  // has been accepted. Valid stays high between back-to-back words.
  task automatic send_word(input logic [31:0] value, input logic [2:0] byte_count);
    int unsigned gap;
    gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, byte_count, value};
    do @(posedge clk_i); while (!s_axis_tready);
    digits_sb.note_input(value, byte_count);
  endtask

  // Mostly legal counts; now and then zero or a count past the maximum.
  function automatic logic [2:0] pick_count();
    logic [2:0] bad_counts[3] = '{3'd0, 3'd6, 3'd7};
    if ($urandom_range(0, 9) == 0) return bad_counts[$urandom_range(0, 2)];
    return 3'($urandom_range(1, b2bcd_pkg::MaxBytesDefault));
  endfunction

  // Mix of full-range values, short values and values around powers of 100 and
  // the top of the range, where carries across digit pairs are most likely wrong.
  function automatic logic [31:0] pick_value();
    logic [31:0] powers[5] = '{32'd1, 32'd100, 32'd10000, 32'd1000000, 32'd100000000};
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 99);
      1:       return $urandom_range(0, 999999);
      2:       return powers[$urandom_range(0, 4)] - 32'($urandom_range(0, 1));
      3:       return 32'hFFFF_FFFF - 32'($urandom_range(0, 1000));
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [31:0] edge_values[9] = '{32'd0, 32'hFFFF_FFFF, 32'd99, 32'd100, 32'd9999,
                                    32'd1234567890, 32'd99999999, 32'd100000000,
                                    32'hAAAA_5555};
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: all-ones at every legal count, zero at the full count, each rejected count,
    // and values that sit on digit-pair boundaries.
    for (int n = 1; n <= 5; n++) send_word(32'hFFFF_FFFF, 3'(n));
    send_word(32'd0, 3'd5);
    send_word(32'hFFFF_FFFF, 3'd0);
    send_word(32'hFFFF_FFFF, 3'd6);
    send_word(32'd0, 3'd7);
    foreach (edge_values[k]) send_word(edge_values[k], 3'd5);
    send_word(32'd100, 3'd1);
    send_word(32'd10000, 3'd2);

    // Random part; the last stretch runs with both sides always ready.
    for (int n = 0; n < 450; n++) begin
      if (n == 380) idling_on = 1'b0;
      send_word(pick_value(), pick_count());
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (digits_sb.pending() != 0) @(posedge clk_i);
    // Let any stray extra word show up before the verdict.
    repeat (20) @(posedge clk_i);
    if (digits_sb.mismatches == 0 && digits_sb.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/b2bcd_pkg.sv
hw/rtl/b2bcd_front.sv
hw/rtl/b2bcd_fifo.sv
hw/rtl/b2bcd_back.sv
hw/rtl/binary_to_packed_bcd.sv
tb/sv/tb_top.sv
